// File: design/ftl_pkg.sv
// Shared types, codes and helpers of the log-block translation layer.
package ftl_pkg;

   localparam int MAX_PAGES       = 65536;
   localparam int MAX_DATA_BLOCKS = 4096;
   localparam int MAX_LOG_BLOCKS  = 64;
   localparam int PCT_BASE        = 100;
   localparam int NUM_REGS        = 6;

   // ceil(2^37 / PCT_BASE): exact quotient by reciprocal for 32-bit dividends
   localparam logic [30:0] PCT_RECIP = 31'h51EB851F;

   localparam logic [2:0] REG_PKG    = 3'd0;
   localparam logic [2:0] REG_DIE    = 3'd1;
   localparam logic [2:0] REG_PLANE  = 3'd2;
   localparam logic [2:0] REG_BLOCK  = 3'd3;
   localparam logic [2:0] REG_PAGE   = 3'd4;
   localparam logic [2:0] REG_OP     = 3'd5;

   localparam logic [2:0] OP_BLK   = 3'd0;
   localparam logic [2:0] OP_PKG   = 3'd1;
   localparam logic [2:0] OP_DIE   = 3'd2;
   localparam logic [2:0] OP_PLANE = 3'd3;
   localparam logic [2:0] OP_BLOCK = 3'd4;

   typedef struct packed {
      logic       accept;
      logic       clr;
      logic       clr_start;
      logic       div_start;
      logic [2:0] div_op;
      logic       init_state;
      logic       wmap_set;
      logic       claim;
      logic       cap_k;
      logic       append;
      logic       cap_slot;
      logic       dec_lba;
      logic       dec_base;
      logic       page_fix;
      logic       deliver;
      logic       fail;
   } ftl_cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic clr_done;
      logic div_done;
      logic req_type;
      logic written;
      logic in_range;
      logic blk_ok;
      logic d2l_valid;
      logic exhaust;
      logic fill_full;
      logic slot_valid;
      logic out_full;
   } ftl_stat_type;

   function automatic logic [10:0] clampv(input logic [10:0] v, input logic [10:0] hi);
      logic [10:0] r;
      if (v == 11'd0) r = 11'd1;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

// File: design/ftl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ftl_div
   import ftl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        short_op,
   input  logic [23:0] dividend,
   input  logic [24:0] divisor,
   output logic        done,
   output logic [23:0] quo,
   output logic [24:0] rem
);

   logic [24:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [23:0] dvd_ff, dvd_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [25:0] trial;
   logic        fits;

   assign trial = {rem_ff, dvd_ff[23]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = '0;
         dvd_in  = short_op ? {dividend[15:0], 8'd0} : dividend;
         cnt_in  = short_op ? 5'd16 : 5'd24;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 25'(trial - {1'b0, divisor}) : trial[24:0];
         quo_in = {quo_ff[22:0], fits};
         dvd_in = {dvd_ff[22:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvd_ff <= dvd_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// File: design/ftl_datapath.sv
// Datapath: configuration, geometry, mapping tables, divider and result register.
module ftl_datapath
   import ftl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [10:0]  csr_wdata,
   input  logic         req_tuser,
   input  logic [15:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,
   output logic [31:0]  rsp_tdata,
   input  ftl_cmd_type  cmd,
   output ftl_stat_type stat
);

   logic [4:0]  cfg_p_ff, cfg_d_ff, cfg_l_ff;
   logic [10:0] cfg_b_ff;
   logic [6:0]  cfg_g_ff, cfg_op_ff;
   logic [10:0] gp_c, gd_c, gl_c, gb_c, gg_c;
   logic [6:0]  op_c;

   logic [17:0] t3_p;
   logic [21:0] t2_p;
   logic [25:0] t1_p;
   logic [29:0] raw_p;
   logic [23:0] opx_p;
   logic [54:0] lcap_p;
   logic [16:0] t3_ff;
   logic [20:0] t2_ff;
   logic [24:0] t1_ff;
   logic [16:0] raw_ff;
   logic [23:0] opx_ff;

   logic        type_ff;
   logic [15:0] lba_ff, blk_ff, dec_a_ff, lcap_ff;
   logic [5:0]  page_ff, k_ff, slot_ff;
   logic [16:0] dcap_ff, nfree_ff, dcap_w;
   logic [6:0]  log_cnt_ff;
   logic [12:0] clr_cnt_ff;
   logic        clr_act;

   logic [2:0]  op_ff;
   logic [23:0] div_dvd, div_quo;
   logic [24:0] div_dsr, div_rem;
   logic        div_done;

   logic [3:0]  fld_pkg_ff, fld_die_ff, fld_plane_ff;
   logic [9:0]  fld_block_ff;
   logic [5:0]  fld_page_ff;

   logic        out_valid_ff, out_status_ff;
   logic [27:0] out_data_ff;

   logic [15:0] wmap_mem [0:4095];
   logic [6:0]  d2l_mem  [0:4095];
   logic [6:0]  slot_mem [0:4095];
   logic [15:0] lbase_mem [0:63];
   logic [6:0]  lfill_mem [0:63];
   logic [15:0] wmap_rd_ff, lbase_rd_ff;
   logic [6:0]  d2l_rd_ff, slot_rd_ff, lfill_rd_ff;

   logic        wmap_we, d2l_we, slot_we, lfill_we;
   logic [11:0] wmap_wa, d2l_wa, slot_wa, slot_ra;
   logic [15:0] wmap_wd;
   logic [6:0]  d2l_wd, slot_wd, lfill_wd;
   logic [5:0]  lfill_wa;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_p_ff  <= 5'd1;
         cfg_d_ff  <= 5'd1;
         cfg_l_ff  <= 5'd1;
         cfg_b_ff  <= 11'd64;
         cfg_g_ff  <= 7'd64;
         cfg_op_ff <= 7'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PKG:   cfg_p_ff  <= csr_wdata[4:0];
            REG_DIE:   cfg_d_ff  <= csr_wdata[4:0];
            REG_PLANE: cfg_l_ff  <= csr_wdata[4:0];
            REG_BLOCK: cfg_b_ff  <= csr_wdata;
            REG_PAGE:  cfg_g_ff  <= csr_wdata[6:0];
            REG_OP:    cfg_op_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign gp_c = clampv({6'd0, cfg_p_ff}, 11'd16);
   assign gd_c = clampv({6'd0, cfg_d_ff}, 11'd16);
   assign gl_c = clampv({6'd0, cfg_l_ff}, 11'd16);
   assign gb_c = clampv(cfg_b_ff, 11'd1024);
   assign gg_c = clampv({4'd0, cfg_g_ff}, 11'd64);
   assign op_c = (cfg_op_ff > 7'd99) ? 7'd99 : cfg_op_ff;

   // geometry products, one multiply per stage
   assign t3_p   = gb_c * gg_c[6:0];
   assign t2_p   = gl_c[4:0] * t3_ff;
   assign t1_p   = gd_c[4:0] * t2_ff;
   assign raw_p  = gp_c[4:0] * t1_ff;
   assign opx_p  = raw_ff * op_c;
   assign lcap_p = {31'd0, opx_ff} * {24'd0, PCT_RECIP};

   always_ff @(posedge clock) begin
      t3_ff   <= t3_p[16:0];
      t2_ff   <= t2_p[20:0];
      t1_ff   <= t1_p[24:0];
      raw_ff  <= (raw_p > 30'(MAX_PAGES)) ? 17'(MAX_PAGES) : raw_p[16:0];
      opx_ff  <= opx_p;
      lcap_ff <= lcap_p[52:37];
   end

   // divider
   always_comb begin
      case (cmd.div_op) inside
         OP_BLK:                       div_dvd = {8'd0, lba_ff};
         OP_PKG:                       div_dvd = {8'd0, dec_a_ff};
         OP_DIE, OP_PLANE, OP_BLOCK:   div_dvd = div_rem[23:0];
         default:                      div_dvd = '0;
      endcase
      case (op_ff) inside
         OP_BLK, OP_BLOCK: div_dsr = {18'd0, gg_c[6:0]};
         OP_PKG:           div_dsr = t1_ff;
         OP_DIE:           div_dsr = {4'd0, t2_ff};
         OP_PLANE:         div_dsr = {8'd0, t3_ff};
         default:          div_dsr = 25'd1;
      endcase
   end

   ftl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .short_op (1'b1),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign dcap_w  = raw_ff - {1'b0, lcap_ff};
   assign clr_act = cmd.clr && !clr_cnt_ff[12];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         log_cnt_ff   <= '0;
         nfree_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_start) clr_cnt_ff <= '0;
         else if (clr_act) clr_cnt_ff <= clr_cnt_ff + 13'd1;
         if (cmd.init_state) begin
            log_cnt_ff <= '0;
            nfree_ff   <= dcap_w;
         end else if (cmd.claim) begin
            log_cnt_ff <= log_cnt_ff + 7'd1;
            nfree_ff   <= nfree_ff + {10'd0, gg_c[6:0]};
         end
         if (cmd.deliver) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.div_start) op_ff <= cmd.div_op;
      if (cmd.accept) begin
         type_ff <= req_tuser;
         lba_ff  <= req_tdata;
      end
      if (cmd.init_state) dcap_ff <= dcap_w;
      if (cmd.dec_lba) dec_a_ff <= lba_ff;
      else if (cmd.dec_base) dec_a_ff <= lbase_rd_ff;
      if (cmd.claim) k_ff <= log_cnt_ff[5:0];
      else if (cmd.cap_k) k_ff <= d2l_rd_ff[5:0];
      if (cmd.cap_slot) slot_ff <= slot_rd_ff[5:0];
      else if (cmd.append) slot_ff <= lfill_rd_ff[5:0];
      if (div_done) begin
         case (op_ff)
            OP_BLK: begin
               blk_ff  <= div_quo[15:0];
               page_ff <= div_rem[5:0];
            end
            OP_PKG:   fld_pkg_ff   <= div_quo[3:0];
            OP_DIE:   fld_die_ff   <= div_quo[3:0];
            OP_PLANE: fld_plane_ff <= div_quo[3:0];
            OP_BLOCK: begin
               fld_block_ff <= div_quo[9:0];
               fld_page_ff  <= cmd.page_fix ? slot_ff : div_rem[5:0];
            end
            default: ;
         endcase
      end
      if (cmd.deliver) begin
         out_status_ff <= cmd.fail;
         out_data_ff   <= cmd.fail ? 28'd0 :
                          {fld_page_ff, fld_block_ff, fld_plane_ff, fld_die_ff, fld_pkg_ff};
      end
   end

   // table write ports
   assign slot_ra  = {k_ff, page_ff};
   assign wmap_we  = clr_act || cmd.wmap_set;
   assign wmap_wa  = clr_act ? clr_cnt_ff[11:0] : lba_ff[15:4];
   assign wmap_wd  = clr_act ? 16'd0 : (wmap_rd_ff | (16'd1 << lba_ff[3:0]));
   assign d2l_we   = clr_act || cmd.claim;
   assign d2l_wa   = clr_act ? clr_cnt_ff[11:0] : blk_ff[11:0];
   assign d2l_wd   = clr_act ? 7'd0 : {1'b1, log_cnt_ff[5:0]};
   assign slot_we  = clr_act || cmd.append;
   assign slot_wa  = clr_act ? clr_cnt_ff[11:0] : slot_ra;
   assign slot_wd  = clr_act ? 7'd0 : {1'b1, lfill_rd_ff[5:0]};
   assign lfill_we = cmd.claim || cmd.append;
   assign lfill_wa = cmd.claim ? log_cnt_ff[5:0] : k_ff;
   assign lfill_wd = cmd.claim ? 7'd0 : lfill_rd_ff + 7'd1;

   always_ff @(posedge clock) begin
      if (wmap_we) wmap_mem[wmap_wa] <= wmap_wd;
      wmap_rd_ff <= wmap_mem[lba_ff[15:4]];
   end

   always_ff @(posedge clock) begin
      if (d2l_we) d2l_mem[d2l_wa] <= d2l_wd;
      d2l_rd_ff <= d2l_mem[blk_ff[11:0]];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.claim) lbase_mem[log_cnt_ff[5:0]] <= nfree_ff[15:0];
      lbase_rd_ff <= lbase_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (lfill_we) lfill_mem[lfill_wa] <= lfill_wd;
      lfill_rd_ff <= lfill_mem[k_ff];
   end

   // status
   assign stat.cfg_wr     = csr_we && (csr_index < 3'(NUM_REGS));
   assign stat.clr_done   = clr_cnt_ff[12];
   assign stat.div_done   = div_done;
   assign stat.req_type   = type_ff;
   assign stat.written    = wmap_rd_ff[lba_ff[3:0]];
   assign stat.in_range   = {1'b0, lba_ff} < dcap_ff;
   assign stat.blk_ok     = blk_ff < 16'(MAX_DATA_BLOCKS);
   assign stat.d2l_valid  = d2l_rd_ff[6];
   assign stat.exhaust    = (nfree_ff >= raw_ff) || (log_cnt_ff >= 7'(MAX_LOG_BLOCKS));
   assign stat.fill_full  = lfill_rd_ff >= gg_c[6:0];
   assign stat.slot_valid = slot_rd_ff[6];
   assign stat.out_full   = out_valid_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {4'd0, out_data_ff};

endmodule

// File: design/ftl_ctrl.sv
// Controller: sequences clearing, geometry setup and each translation.
module ftl_ctrl
   import ftl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ftl_stat_type stat,
   output ftl_cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd3;
   localparam logic [3:0] S_BLKS  = 4'd4;
   localparam logic [3:0] S_BLKW  = 4'd5;
   localparam logic [3:0] S_CHK   = 4'd6;
   localparam logic [3:0] S_WD2L  = 4'd7;
   localparam logic [3:0] S_WWAIT = 4'd8;
   localparam logic [3:0] S_WFILL = 4'd9;
   localparam logic [3:0] S_RD2L  = 4'd10;
   localparam logic [3:0] S_RWAIT = 4'd11;
   localparam logic [3:0] S_RSLOT = 4'd12;
   localparam logic [3:0] S_DS    = 4'd13;
   localparam logic [3:0] S_DW    = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   localparam logic [1:0] RET_OUT = 2'd0;
   localparam logic [1:0] RET_RD  = 2'd1;
   localparam logic [1:0] RET_FIX = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] ret_ff, ret_in;
   logic [1:0] dcnt_ff, dcnt_in;
   logic       fail_ff, fail_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      dcnt_in  = dcnt_ff;
      fail_in  = fail_ff;
      cmd      = '0;
      if (stat.cfg_wr) begin
         cmd.clr_start = 1'b1;
         state_in      = S_CLEAR;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               cmd.clr = 1'b1;
               if (stat.clr_done) begin
                  cmd.init_state = 1'b1;
                  state_in       = S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd.accept = 1'b1;
                  state_in   = S_BLKS;
               end
            end
            S_BLKS: begin
               cmd.div_start = 1'b1;
               cmd.div_op    = OP_BLK;
               state_in      = S_BLKW;
            end
            S_BLKW: begin
               if (stat.div_done) state_in = S_CHK;
            end
            S_CHK: begin
               dcnt_in = 2'd0;
               fail_in = 1'b0;
               if (!stat.in_range || (!stat.req_type && !stat.written)) begin
                  fail_in  = 1'b1;
                  state_in = S_OUT;
               end else if (!stat.req_type) begin
                  cmd.dec_lba = 1'b1;
                  ret_in      = RET_RD;
                  state_in    = S_DS;
               end else if (!stat.written) begin
                  cmd.wmap_set = 1'b1;
                  cmd.dec_lba  = 1'b1;
                  ret_in       = RET_OUT;
                  state_in     = S_DS;
               end else if (!stat.blk_ok) begin
                  fail_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_WD2L;
               end
            end
            S_WD2L: begin
               if (stat.d2l_valid) begin
                  cmd.cap_k = 1'b1;
                  state_in  = S_WWAIT;
               end else if (stat.exhaust) begin
                  fail_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  cmd.claim = 1'b1;
                  state_in  = S_WWAIT;
               end
            end
            S_WWAIT: state_in = S_WFILL;
            S_WFILL: begin
               if (stat.fill_full) begin
                  fail_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  cmd.append   = 1'b1;
                  cmd.dec_base = 1'b1;
                  ret_in       = RET_FIX;
                  state_in     = S_DS;
               end
            end
            S_RD2L: begin
               if (stat.blk_ok && stat.d2l_valid) begin
                  cmd.cap_k = 1'b1;
                  state_in  = S_RWAIT;
               end else begin
                  state_in = S_OUT;
               end
            end
            S_RWAIT: state_in = S_RSLOT;
            S_RSLOT: begin
               if (stat.slot_valid) begin
                  cmd.cap_slot = 1'b1;
                  cmd.dec_base = 1'b1;
                  dcnt_in      = 2'd0;
                  ret_in       = RET_FIX;
                  state_in     = S_DS;
               end else begin
                  state_in = S_OUT;
               end
            end
            S_DS: begin
               cmd.div_start = 1'b1;
               cmd.div_op    = OP_PKG + {1'b0, dcnt_ff};
               state_in      = S_DW;
            end
            S_DW: begin
               if (stat.div_done) begin
                  if (dcnt_ff == 2'd3) begin
                     dcnt_in = 2'd0;
                     case (ret_ff)
                        RET_RD:  state_in = S_RD2L;
                        RET_FIX: begin
                           cmd.page_fix = 1'b1;
                           state_in     = S_OUT;
                        end
                        default: state_in = S_OUT;
                     endcase
                  end else begin
                     dcnt_in  = dcnt_ff + 2'd1;
                     state_in = S_DS;
                  end
               end
            end
            S_OUT: begin
               if (!stat.out_full) begin
                  cmd.deliver = 1'b1;
                  cmd.fail    = fail_ff;
                  state_in    = S_IDLE;
               end
            end
            default: state_in = S_CLEAR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff   <= RET_OUT;
         dcnt_ff  <= 2'd0;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         dcnt_ff  <= dcnt_in;
         fail_ff  <= fail_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// File: design/log_block_ftl_translate.sv
// Top level of the log-block flash translation layer.
//
// req channel: one word per translation; tuser is the request type (0 read,
// 1 write), tdata the logical page. rsp channel: one word per request; tuser
// is the status (1 failure, all address fields zero), tdata the physical
// address. csr port: write enable, register index and data, written at once.
//
// The result word follows its request through a pass of the shared divider
// for the block number, then four passes for each address decomposition
// (home address, and log block base on a log hit or append), plus table
// reads. One request is in work at a time.
//
// After reset and after every configuration write the tables are cleared,
// one entry a cycle; requests are held off meanwhile. A finished word waits
// in the output register while rsp_tready is low; the block takes the next
// request and holds its result until the word is taken.
module log_block_ftl_translate
   import ftl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // req_type
   input  logic [15:0] req_tdata,   // lba
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // status
   output logic [31:0] rsp_tdata    // pkg_index, die_index, plane_index, block_index, page_index
);

   ftl_cmd_type  cmd;
   ftl_stat_type stat;

   ftl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ftl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the log-block flash translation layer.
`timescale 1ns / 100ps

module tb_top;
   import ftl_pkg::*;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;
   localparam int   SETTLE    = 200;

   typedef enum logic [1:0] {K_ITEM, K_CFG, K_PAUSE} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic          rtype;
      logic [15:0]   lba;
      logic [2:0]    idx;
      logic [10:0]   val;
   } step_type;

   typedef struct {
      logic        status;
      logic [31:0] addr;
   } xlat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;
   logic [31:0] rsp_tdata;

   log_block_ftl_translate u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // translation state shadow
   logic [5:0][10:0] geo_regs;
   bit               written_map [MAX_PAGES];
   bit               d2l_valid [MAX_DATA_BLOCKS];
   logic [5:0]       d2l_log [MAX_DATA_BLOCKS];
   bit               slot_valid [MAX_LOG_BLOCKS*64];
   logic [5:0]       slot_pos [MAX_LOG_BLOCKS*64];
   int unsigned      log_base [MAX_LOG_BLOCKS];
   int unsigned      log_fill [MAX_LOG_BLOCKS];
   int unsigned      next_log_page;
   int unsigned      log_used;

   step_type    pend_q[$];
   xlat_type    xlat_q[$];
   int          errors = 0;
   int          mism = 0;
   int          quiet = 0;
   int          rsp_seen = 0;
   int          gap = 0;
   int          stall = 0;
   int          hold_left = 0;
   bit          hold_done = 0;
   bit          req_taken = 0;
   bit          all_sent = 0;
   bit          tail = 0;

   function automatic int unsigned clampu(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void geometry(input logic [5:0][10:0] r,
                                    output int unsigned gp, gd, gl, gb, gg,
                                    output int unsigned raw, dcap);
      longint unsigned prod;
      int unsigned op;
      gp = clampu(r[REG_PKG], 16);
      gd = clampu(r[REG_DIE], 16);
      gl = clampu(r[REG_PLANE], 16);
      gb = clampu(r[REG_BLOCK], 1024);
      gg = clampu(r[REG_PAGE], 64);
      prod = longint'(gp) * gd * gl * gb * gg;
      raw = (prod > MAX_PAGES) ? MAX_PAGES : int'(prod);
      op = (r[REG_OP] > 99) ? 99 : r[REG_OP];
      dcap = raw - (raw * op) / PCT_BASE;
   endfunction

   function automatic logic [31:0] phys_addr(int unsigned a);
      int unsigned gp, gd, gl, gb, gg, raw, dcap, t1, t2, t3;
      logic [3:0] pk, di, pl;
      logic [9:0] bk;
      logic [5:0] pg;
      geometry(geo_regs, gp, gd, gl, gb, gg, raw, dcap);
      t3 = gb * gg;
      t2 = gl * t3;
      t1 = gd * t2;
      pk = 4'((a / t1) & 32'hF);  a = a % t1;
      di = 4'((a / t2) & 32'hF);  a = a % t2;
      pl = 4'((a / t3) & 32'hF);  a = a % t3;
      bk = 10'((a / gg) & 32'h3FF);
      pg = 6'((a % gg) & 32'h3F);
      return {4'd0, pg, bk, pl, di, pk};
   endfunction

   function automatic void clear_tables();
      int unsigned gp, gd, gl, gb, gg, raw, dcap;
      geometry(geo_regs, gp, gd, gl, gb, gg, raw, dcap);
      foreach (written_map[i]) written_map[i] = 0;
      foreach (d2l_valid[i]) d2l_valid[i] = 0;
      foreach (slot_valid[i]) slot_valid[i] = 0;
      foreach (log_fill[i]) log_fill[i] = 0;
      foreach (log_base[i]) log_base[i] = 0;
      next_log_page = dcap;
      log_used = 0;
   endfunction

   function automatic void write_geo(logic [2:0] idx, logic [10:0] val);
      case (idx) inside
         REG_PKG, REG_DIE, REG_PLANE: geo_regs[idx] = val & 11'h1F;
         REG_BLOCK:                   geo_regs[idx] = val;
         REG_PAGE, REG_OP:            geo_regs[idx] = val & 11'h7F;
         default: ;
      endcase
      clear_tables();
   endfunction

   function automatic xlat_type translate(logic rtype, logic [15:0] lba);
      int unsigned gp, gd, gl, gb, gg, raw, dcap, page, blk, k;
      xlat_type res;
      geometry(geo_regs, gp, gd, gl, gb, gg, raw, dcap);
      page = lba % gg;
      blk = lba / gg;
      res.status = 1'b1;
      res.addr = '0;
      if (rtype == REQ_READ) begin
         if (!written_map[lba] || lba >= dcap) return res;
         res.status = 1'b0;
         res.addr = phys_addr(lba);
         if (blk >= MAX_DATA_BLOCKS || !d2l_valid[blk]) return res;
         k = d2l_log[blk];
         if (slot_valid[k*64 + page]) begin
            res.addr = phys_addr(log_base[k]);
            res.addr[27:22] = slot_pos[k*64 + page];
         end
         return res;
      end
      if (lba >= dcap) return res;
      if (!written_map[lba]) begin
         written_map[lba] = 1;
         res.status = 1'b0;
         res.addr = phys_addr(lba);
         return res;
      end
      if (blk >= MAX_DATA_BLOCKS) return res;
      if (!d2l_valid[blk]) begin
         if (next_log_page >= raw || log_used >= MAX_LOG_BLOCKS) return res;
         k = log_used;
         log_base[k] = next_log_page;
         log_fill[k] = 0;
         for (int s = 0; s < 64; s++) slot_valid[k*64 + s] = 0;
         next_log_page += gg;
         log_used++;
         d2l_valid[blk] = 1;
         d2l_log[blk] = 6'(k);
      end
      k = d2l_log[blk];
      if (log_fill[k] >= gg) return res;
      slot_valid[k*64 + page] = 1;
      slot_pos[k*64 + page] = 6'(log_fill[k]);
      res.status = 1'b0;
      res.addr = phys_addr(log_base[k]);
      res.addr[27:22] = 6'(log_fill[k]);
      log_fill[k]++;
      return res;
   endfunction

   // stimulus planning
   logic [5:0][10:0] plan_regs;

   task automatic add_item(logic rtype, logic [15:0] lba);
      step_type s;
      s.kind = K_ITEM; s.rtype = rtype; s.lba = lba; s.idx = '0; s.val = '0;
      pend_q.push_back(s);
   endtask

   task automatic add_geo(logic [10:0] p, logic [10:0] d, logic [10:0] l,
                          logic [10:0] b, logic [10:0] g, logic [10:0] op);
      step_type s;
      logic [10:0] v [6];
      v[0] = p; v[1] = d; v[2] = l; v[3] = b; v[4] = g; v[5] = op;
      s.kind = K_CFG; s.rtype = 1'b0; s.lba = '0;
      for (int i = 0; i < 6; i++) begin
         s.idx = 3'(i);
         s.val = v[i];
         pend_q.push_back(s);
         plan_regs[i] = v[i];
      end
   endtask

   task automatic add_pause();
      step_type s;
      s.kind = K_PAUSE; s.rtype = 1'b0; s.lba = '0; s.idx = '0; s.val = '0;
      pend_q.push_back(s);
   endtask

   function automatic logic [10:0] pick_small(int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 11'd0;
      if (r == 1) return 11'h1F;
      return 11'($urandom_range(1, hi));
   endfunction

   task automatic random_phase(int n, bit with_pause);
      int unsigned gp, gd, gl, gb, gg, raw, dcap, span, r, top;
      logic [10:0] g, b, op;
      r = $urandom_range(0, 4);
      g = (r == 0) ? 11'd1 : (r == 1) ? 11'd2 : (r == 2) ? 11'd4 :
          (r == 3) ? 11'($urandom_range(1, 64)) : 11'($urandom_range(0, 127));
      r = $urandom_range(0, 7);
      b = (r == 0) ? 11'd0 : (r == 1) ? 11'h7FF : 11'($urandom_range(1, 64));
      r = $urandom_range(0, 7);
      op = (r == 0) ? 11'd0 : (r == 1) ? 11'd99 : (r == 2) ? 11'h7F :
           11'($urandom_range(1, 98));
      add_geo(pick_small(4), pick_small(4), pick_small(4), b, g, op);
      geometry(plan_regs, gp, gd, gl, gb, gg, raw, dcap);
      span = gg * $urandom_range(1, 80);
      if (span > dcap) span = dcap;
      top = (dcap + 16 > 65535) ? 65535 : dcap + 16;
      for (int i = 0; i < n; i++) begin
         if (with_pause && i == n / 2) add_pause();
         r = $urandom_range(0, 99);
         if (r < 55) add_item(REQ_WRITE, 16'($urandom_range(0, span - 1)));
         else if (r < 80) add_item(REQ_READ, 16'($urandom_range(0, span - 1)));
         else if (r < 92) add_item(1'($urandom), 16'($urandom_range(0, top)));
         else add_item(1'($urandom), 16'($urandom));
      end
   endtask

   // request driver
   always @(negedge clock) begin
      logic nv, nwe;
      step_type s;
      if (!reset) begin
         nv = req_tvalid;
         nwe = 1'b0;
         tail = (pend_q.size() < 120);
         if (!req_tvalid || req_taken) begin
            nv = 1'b0;
            if (gap > 0) begin
               gap--;
            end else if (pend_q.size() > 0) begin
               s = pend_q[0];
               case (s.kind)
                  K_ITEM: begin
                     nv = 1'b1;
                     req_tuser <= s.rtype;
                     req_tdata <= s.lba;
                     void'(pend_q.pop_front());
                     if (!tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 10);
                  end
                  K_CFG: if (xlat_q.size() == 0 && quiet >= SETTLE) begin
                     nwe = 1'b1;
                     csr_index <= s.idx;
                     csr_wdata <= s.val;
                     write_geo(s.idx, s.val);
                     void'(pend_q.pop_front());
                  end
                  default: if (xlat_q.size() == 0 && quiet >= SETTLE) begin
                     void'(pend_q.pop_front());
                  end
               endcase
            end else begin
               all_sent = 1;
            end
         end
         req_tvalid <= nv;
         csr_we <= nwe;
      end
   end

   // result backpressure
   always @(negedge clock) begin
      logic rdy;
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (!hold_done && rsp_seen >= 400) begin
            hold_done = 1;
            hold_left = 3000;
            rdy = 1'b0;
         end else if (stall > 0) begin
            stall--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
            if (!tail && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 10);
         end
         rsp_tready <= rdy;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      xlat_type want;
      req_taken = 0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (xlat_q.size() == 0) begin
               errors++;
               if (mism < 10) $display("unexpected word: status %0d addr %h",
                                       rsp_tuser, rsp_tdata);
               mism++;
            end else begin
               want = xlat_q.pop_front();
               if (want.status !== rsp_tuser || want.addr !== rsp_tdata) begin
                  errors++;
                  if (mism < 10)
                     $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                              want.status, want.addr, rsp_tuser, rsp_tdata);
                  mism++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1;
            xlat_q.push_back(translate(req_tuser, req_tdata));
         end
         quiet = (xlat_q.size() == 0) ? quiet + 1 : 0;
      end
   end

   initial begin
      geo_regs[REG_PKG] = 11'd1;
      geo_regs[REG_DIE] = 11'd1;
      geo_regs[REG_PLANE] = 11'd1;
      geo_regs[REG_BLOCK] = 11'd64;
      geo_regs[REG_PAGE] = 11'd64;
      geo_regs[REG_OP] = 11'd10;
      clear_tables();
      plan_regs = geo_regs;

      // reset geometry: unwritten, range edges, home and log addresses
      add_item(REQ_READ, 16'd0);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_READ, 16'd0);
      add_item(REQ_READ, 16'hFFFF);
      add_item(REQ_WRITE, 16'hFFFF);
      add_item(REQ_WRITE, 16'd3686);
      add_item(REQ_WRITE, 16'd3686);
      add_item(REQ_READ, 16'd3686);
      add_item(REQ_WRITE, 16'd3687);
      add_item(REQ_READ, 16'd3687);
      // two-page blocks: fill a log block to its end
      add_geo(11'd1, 11'd1, 11'd1, 11'd4, 11'd2, 11'd50);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_WRITE, 16'd1);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_READ, 16'd1);
      add_item(REQ_WRITE, 16'd2);
      add_item(REQ_WRITE, 16'd2);
      add_item(REQ_READ, 16'd3);
      // clamped extremes
      add_geo(11'h1F, 11'h1F, 11'h1F, 11'h7FF, 11'h7F, 11'h7F);
      add_item(REQ_WRITE, 16'd655);
      add_item(REQ_WRITE, 16'd655);
      add_item(REQ_READ, 16'd655);
      add_item(REQ_WRITE, 16'd656);
      // full capacity, no log space, blocks beyond the table
      add_geo(11'd16, 11'd16, 11'd16, 11'd16, 11'd1, 11'd0);
      add_item(REQ_WRITE, 16'd5000);
      add_item(REQ_WRITE, 16'd5000);
      add_item(REQ_READ, 16'd5000);
      add_item(REQ_WRITE, 16'd7);
      add_item(REQ_WRITE, 16'd7);
      add_item(REQ_WRITE, 16'hFFFF);
      add_item(REQ_READ, 16'hFFFF);
      // all-zero registers
      add_geo(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_WRITE, 16'd0);
      add_item(REQ_READ, 16'd0);

      for (int p = 0; p < 10; p++) random_phase(190, p == 2 || p == 6);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (!all_sent || req_tvalid || xlat_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && xlat_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
